FILE: hdl/msq_pkg.sv
`default_nettype none
package msq_pkg;

    // register list geometry
    localparam int LIST_LEN  = 16;
    localparam int IDX_W     = $clog2(LIST_LEN);
    localparam int ADDR_W    = 32;

    // addressing modes and PC-relative register codes
    localparam logic [2:0] MODE_POSTINC  = 3'd3;
    localparam logic [2:0] MODE_PREDEC   = 3'd4;
    localparam logic [2:0] MODE_EXTENDED = 3'd7;
    localparam logic [2:0] REG_PC_DISP   = 3'd2;
    localparam logic [2:0] REG_PC_INDEX  = 3'd3;

    // classified instruction handed from front to back
    typedef struct packed {
        logic                 illegal;
        logic                 predec;
        logic                 to_reg;
        logic                 pspace;
        logic                 wb;
        logic                 long_size;
        logic [2:0]           base;
        logic [LIST_LEN-1:0]  mask;
        logic [ADDR_W-1:0]    addr;
    } t_cmd;

    // one result beat
    typedef struct packed {
        logic              transfer_valid;
        logic [IDX_W-1:0]  register_index;
        logic [ADDR_W-1:0] transfer_address;
        logic              is_write;
        logic              use_initial_base;
        logic              program_space;
        logic              writeback_valid;
        logic [ADDR_W-1:0] writeback_value;
        logic              illegal;
        logic              last;
    } t_result;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

endpackage
`default_nettype wire

FILE: hdl/movem_transfer_sequencer.sv
// MOVEM sequencer: one instruction in, one beat out per selected register.
// Each instruction yields N beats, N the number of set list bits
// (N = 1 for an empty list or the illegal form). The back sequencer
// loads a command only while idle and emits one transfer per cycle
// while its output slot is free; two commands queue in front of it.
// Reset: synchronous, active low; clears queue, sequencer and output valid.
`default_nettype none
module movem_transfer_sequencer import msq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 i_to_registers,
    input  wire logic                 i_long_size,
    input  wire logic [2:0]           i_ea_mode,
    input  wire logic [2:0]           i_ea_reg,
    input  wire logic [LIST_LEN-1:0]  i_register_mask,
    input  wire logic [ADDR_W-1:0]    i_start_address,
    output logic                      empty,
    input  wire logic                 pop,
    output logic                      o_transfer_valid,
    output logic [IDX_W-1:0]          o_register_index,
    output logic [ADDR_W-1:0]         o_transfer_address,
    output logic                      o_is_write,
    output logic                      o_use_initial_base,
    output logic                      o_program_space,
    output logic                      o_writeback_valid,
    output logic [ADDR_W-1:0]         o_writeback_value,
    output logic                      o_illegal,
    output logic                      o_last
);

    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_take;
    logic    w_result_valid;
    t_result w_result;

    // classify and queue
    msq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_to_registers  (i_to_registers),
        .i_long_size     (i_long_size),
        .i_ea_mode       (i_ea_mode),
        .i_ea_reg        (i_ea_reg),
        .i_register_mask (i_register_mask),
        .i_start_address (i_start_address),
        .o_cmd_valid     (w_cmd_valid),
        .o_cmd           (w_cmd),
        .i_cmd_take      (w_cmd_take)
    );

    // transfer sequencer
    msq_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_cmd_valid),
        .i_cmd          (w_cmd),
        .o_cmd_take     (w_cmd_take),
        .i_pop          (pop),
        .o_result_valid (w_result_valid),
        .o_result       (w_result)
    );

    assign empty              = !w_result_valid;
    assign o_transfer_valid   = w_result.transfer_valid;
    assign o_register_index   = w_result.register_index;
    assign o_transfer_address = w_result.transfer_address;
    assign o_is_write         = w_result.is_write;
    assign o_use_initial_base = w_result.use_initial_base;
    assign o_program_space    = w_result.program_space;
    assign o_writeback_valid  = w_result.writeback_valid;
    assign o_writeback_value  = w_result.writeback_value;
    assign o_illegal          = w_result.illegal;
    assign o_last             = w_result.last;

endmodule
`default_nettype wire

FILE: hdl/msq_front.sv
`default_nettype none
module msq_front import msq_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    output logic                      o_full,
    input  wire logic                 i_to_registers,
    input  wire logic                 i_long_size,
    input  wire logic [2:0]           i_ea_mode,
    input  wire logic [2:0]           i_ea_reg,
    input  wire logic [LIST_LEN-1:0]  i_register_mask,
    input  wire logic [ADDR_W-1:0]    i_start_address,
    output logic                      o_cmd_valid,
    output t_cmd                      o_cmd,
    input  wire logic                 i_cmd_take
);

    t_cmd       w_cmd;
    t_cmd       r_queue [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push_ok;
    logic       w_take_ok;

    // classify the instruction
    always_comb begin
        w_cmd.illegal   = i_to_registers && (i_ea_mode == MODE_PREDEC);
        w_cmd.predec    = !i_to_registers && (i_ea_mode == MODE_PREDEC);
        w_cmd.to_reg    = i_to_registers;
        w_cmd.pspace    = i_to_registers && (i_ea_mode == MODE_EXTENDED)
                          && ((i_ea_reg == REG_PC_DISP) || (i_ea_reg == REG_PC_INDEX));
        w_cmd.wb        = (i_to_registers && (i_ea_mode == MODE_POSTINC))
                          || (!i_to_registers && (i_ea_mode == MODE_PREDEC));
        w_cmd.long_size = i_long_size;
        w_cmd.base      = i_ea_reg;
        w_cmd.mask      = i_register_mask;
        w_cmd.addr      = i_start_address;
    end

    assign o_full      = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_queue[r_rd_ptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_take_ok   = i_cmd_take && o_cmd_valid;

    // two-entry command queue storage
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_queue[r_wr_ptr] <= w_cmd;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push_ok) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_take_ok) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({w_push_ok, w_take_ok})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/msq_back.sv
`default_nettype none
module msq_back import msq_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_take,
    input  wire logic i_pop,
    output logic      o_result_valid,
    output t_result   o_result
);

    t_seq_state           r_state;
    t_seq_state           n_state;
    t_cmd                 r_cmd;
    logic [LIST_LEN-1:0]  r_mask;
    logic [LIST_LEN-1:0]  n_mask;
    logic [ADDR_W-1:0]    r_addr;
    logic [ADDR_W-1:0]    n_addr;
    t_result              r_out;
    t_result              n_out;
    logic                 r_out_valid;

    logic                 w_slot_free;
    logic                 w_emit;
    logic                 w_done;
    logic [IDX_W-1:0]     w_low_idx;
    logic [IDX_W-1:0]     w_reg_idx;
    logic [LIST_LEN-1:0]  w_rest_mask;
    logic [ADDR_W-1:0]    w_step;
    logic [ADDR_W-1:0]    w_addr_next;

    assign w_slot_free    = !r_out_valid || i_pop;
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // lowest remaining list bit
    always_comb begin
        w_low_idx = '0;
        for (int k = LIST_LEN - 1; k >= 0; k--) begin
            if (r_mask[k]) begin
                w_low_idx = IDX_W'(k);
            end
        end
    end

    assign w_rest_mask = r_mask & (r_mask - LIST_LEN'(1));
    assign w_step      = r_cmd.long_size ? ADDR_W'(4) : ADDR_W'(2);
    assign w_addr_next = r_cmd.predec ? (r_addr - w_step) : (r_addr + w_step);
    assign w_reg_idx   = r_cmd.predec ? (IDX_W'(LIST_LEN - 1) - w_low_idx) : w_low_idx;
    assign w_done      = r_cmd.illegal || (r_mask == '0) || (w_rest_mask == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (w_slot_free && w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and result beat
    always_comb begin
        o_cmd_take = 1'b0;
        w_emit     = 1'b0;
        n_mask     = r_mask;
        n_addr     = r_addr;
        n_out      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_take = i_cmd_valid;
                n_mask     = i_cmd.mask;
                n_addr     = i_cmd.addr;
            end
            S_RUN: begin
                w_emit = w_slot_free;
                if (r_cmd.illegal) begin
                    n_out.illegal = 1'b1;
                    n_out.last    = 1'b1;
                end else if (r_mask == '0) begin
                    // empty list: one beat carrying only the writeback
                    n_out.last            = 1'b1;
                    n_out.writeback_valid = r_cmd.wb;
                    n_out.writeback_value = r_cmd.wb ? r_addr : '0;
                end else begin
                    n_out.transfer_valid   = 1'b1;
                    n_out.register_index   = w_reg_idx;
                    n_out.transfer_address = r_cmd.predec ? w_addr_next : r_addr;
                    n_out.is_write         = !r_cmd.to_reg;
                    n_out.use_initial_base = r_cmd.predec && (w_reg_idx == {1'b1, r_cmd.base});
                    n_out.program_space    = r_cmd.pspace;
                    n_out.last             = (w_rest_mask == '0);
                    n_out.writeback_valid  = r_cmd.wb && (w_rest_mask == '0);
                    n_out.writeback_value  = (r_cmd.wb && (w_rest_mask == '0)) ?
                                             w_addr_next : '0;
                    n_mask                 = w_rest_mask;
                    n_addr                 = w_addr_next;
                end
            end
            default: begin
                o_cmd_take = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers and output beat
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_cmd <= i_cmd;
        end
        if (o_cmd_take || w_emit) begin
            r_mask <= n_mask;
            r_addr <= n_addr;
        end
        if (w_emit) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire
